@@ src/nla_pkg.sv @@
// ----------------------------------------------------------------------------
// nla_pkg - shared definitions for the noisy Langton's ant stepper
// Register indexes, field widths, reset values and grid sizing defaults.
// ----------------------------------------------------------------------------
package nla_pkg;

  // Default grid capacity.
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // Configuration port sizing.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_THRESHOLD = 3'd5;

  // Register reset values.
  localparam logic [10:0] GRID_WIDTH_RST     = 11'd800;
  localparam logic [10:0] GRID_HEIGHT_RST    = 11'd600;
  localparam logic [9:0]  START_COL_RST      = 10'd400;
  localparam logic [9:0]  START_ROW_RST      = 10'd300;
  localparam logic [1:0]  START_HEADING_RST  = 2'd0;
  localparam logic [3:0]  FLIP_THRESHOLD_RST = 4'd7;

  // Internal position is signed and covers -1 up to the largest grid edge.
  localparam int POS_W = 14;
  // Unsigned width for bounds compares (holds up to 8191).
  localparam int BND_W = 13;

  // Restart generation tag stored with every grid cell.
  localparam int EPOCH_W = 8;

  // Headings.
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

endpackage

@@ src/nla_grid_ram.sv @@
// ----------------------------------------------------------------------------
// nla_grid_ram - grid cell memory
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module nla_grid_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/noisy_langtons_ant_step.sv @@
// ----------------------------------------------------------------------------
// noisy_langtons_ant_step - Langton's ant on a bounded one-bit grid with noise
// Flow: the result register loads as the read state ends, or later from the
//   holding register if the receiver stalls; it is offered until taken.
// Requests are handled one at a time, set by the read-modify-write of one grid
//   cell through the registered-read cell memory.
// Reset: synchronous, active low; then a clearing pass over all MAX_COLS*MAX_ROWS
//   cells runs before the first request, and again after every 256th restart.
// ----------------------------------------------------------------------------
module noisy_langtons_ant_step
  import nla_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [3:0]            in_random_draw,

  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [9:0]            out_flipped_col,
  output logic [9:0]            out_flipped_row,
  output logic                  out_new_colour,
  output logic                  out_did_flip,
  output logic signed [11:0]    out_ant_col,
  output logic signed [11:0]    out_ant_row,
  output logic [1:0]            out_ant_heading,
  output logic                  out_escaped,

  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The grid is stored row by row with a fixed stride of MAX_COLS cells.
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int DW    = EPOCH_W + 1;

  localparam logic [BND_W-1:0] MAX_COLS_B = BND_W'(MAX_COLS);
  localparam logic [BND_W-1:0] MAX_ROWS_B = BND_W'(MAX_ROWS);
  localparam logic [AW-1:0]    LAST_ADDR  = AW'(DEPTH - 1);

  typedef struct packed {
    logic [9:0]  flipped_col;
    logic [9:0]  flipped_row;
    logic        new_colour;
    logic        did_flip;
    logic [11:0] ant_col;
    logic [11:0] ant_row;
    logic [1:0]  ant_heading;
    logic        escaped;
  } result_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_HOLD
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [10:0] grid_width_r;
  logic [10:0] grid_height_r;
  logic [9:0]  start_col_r;
  logic [9:0]  start_row_r;
  logic [1:0]  start_heading_r;
  logic [3:0]  flip_threshold_r;

  // Ant state.
  logic signed [POS_W-1:0] pos_col_r, pos_col_nxt;
  logic signed [POS_W-1:0] pos_row_r, pos_row_nxt;
  logic [1:0]              head_r, head_nxt;
  logic                    esc_r, esc_nxt;

  // Restart generation. A cell whose stored tag differs from the current
  // generation was last written before the latest restart and reads as white.
  logic [EPOCH_W-1:0] epoch_r;
  logic               wipe_r;
  logic [AW-1:0]      clr_cnt_r;

  // Request captured at acceptance, consumed in the read cycle.
  logic          act_r;
  logic [3:0]    draw_r;
  logic          inside_r;
  logic [AW-1:0] addr_r;

  result_t res;
  result_t pend_r;
  result_t out_r;
  logic    out_valid_r;
  logic    out_free;
  logic    out_load;

  // Memory interface.
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [DW-1:0] mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [DW-1:0] mem_rd_data;

  logic [BND_W-1:0] eff_w;
  logic [BND_W-1:0] eff_h;
  logic             in_grid;
  logic             cell_bit;
  logic             noise;
  logic             wipe_now;

  // Bounds of the grid in use, clipped to the storage capacity. A zero width
  // or height leaves no cell inside.
  always_comb begin
    eff_w = (BND_W'(grid_width_r) > MAX_COLS_B) ? MAX_COLS_B : BND_W'(grid_width_r);
    eff_h = (BND_W'(grid_height_r) > MAX_ROWS_B) ? MAX_ROWS_B : BND_W'(grid_height_r);
  end

  // The ant is inside when both coordinates are non-negative and below the
  // bounds. This is evaluated on the current position when a request is
  // accepted, so the width and height in force at that moment apply.
  assign in_grid = !pos_col_r[POS_W-1] && !pos_row_r[POS_W-1] &&
                   (pos_col_r[BND_W-1:0] < eff_w) && (pos_row_r[BND_W-1:0] < eff_h);

  // Cell address of the current position; only meaningful when inside.
  assign mem_rd_addr = AW'(pos_row_r[RIW-1:0]) * AW'(MAX_COLS) + AW'(pos_col_r[CIW-1:0]);
  assign mem_rd_en   = (state_r == S_IDLE) && in_valid;

  // Read data is valid in the read cycle.
  assign cell_bit = (mem_rd_data[DW-1:1] == epoch_r) && mem_rd_data[0];
  assign noise    = draw_r < flip_threshold_r;

  // A restart on the last generation tag reuses the tags only after a full
  // clearing pass, so no stale cell can match again.
  assign wipe_now = !act_r && (&epoch_r);

  // Write port: the clearing pass, or the flip of the cell under the ant.
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_cnt_r;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = (state_r == S_READ) && act_r && inside_r;
      mem_wr_addr = addr_r;
      mem_wr_data = {epoch_r, ~cell_bit};
    end
  end

  // Step logic for the read cycle: next ant state and the result.
  always_comb begin
    pos_col_nxt = pos_col_r;
    pos_row_nxt = pos_row_r;
    head_nxt    = head_r;
    esc_nxt     = esc_r;
    res         = '0;
    if (!act_r) begin
      // Restart: back to the start cell and heading, escaped cleared.
      pos_col_nxt = POS_W'(start_col_r);
      pos_row_nxt = POS_W'(start_row_r);
      head_nxt    = start_heading_r;
      esc_nxt     = 1'b0;
    end else if (!inside_r) begin
      esc_nxt = 1'b1;
    end else begin
      // A set colour (after noise) turns left, a clear one turns right.
      head_nxt = (cell_bit ^ noise) ? head_r - 2'd1 : head_r + 2'd1;
      case (head_nxt)
        HEAD_UP:    pos_row_nxt = pos_row_r - POS_W'(1);
        HEAD_RIGHT: pos_col_nxt = pos_col_r + POS_W'(1);
        HEAD_DOWN:  pos_row_nxt = pos_row_r + POS_W'(1);
        HEAD_LEFT:  pos_col_nxt = pos_col_r - POS_W'(1);
        default:    pos_col_nxt = pos_col_r;
      endcase
      res.flipped_col = pos_col_r[9:0];
      res.flipped_row = pos_row_r[9:0];
      res.new_colour  = ~cell_bit;
      res.did_flip    = 1'b1;
    end
    res.ant_col     = pos_col_nxt[11:0];
    res.ant_row     = pos_row_nxt[11:0];
    res.ant_heading = head_nxt;
    res.escaped     = esc_nxt;
  end

  assign out_free = !out_valid_r || !out_stall;

  // The output register takes a new result from the read cycle or from the
  // holding register whenever it is empty or being emptied.
  assign out_load = out_free && ((state_r == S_READ) || (state_r == S_HOLD));

  // Control, ant state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      epoch_r     <= '0;
      wipe_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_col_r   <= POS_W'(START_COL_RST);
      pos_row_r   <= POS_W'(START_ROW_RST);
      head_r      <= START_HEADING_RST;
      esc_r       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (clr_cnt_r == LAST_ADDR) begin
            clr_cnt_r <= '0;
            state_r   <= S_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act_r    <= in_action;
            draw_r   <= in_random_draw;
            inside_r <= in_grid;
            addr_r   <= mem_rd_addr;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          pos_col_r <= pos_col_nxt;
          pos_row_r <= pos_row_nxt;
          head_r    <= head_nxt;
          esc_r     <= esc_nxt;
          wipe_r    <= wipe_now;
          if (!act_r) begin
            epoch_r <= epoch_r + EPOCH_W'(1);
          end
          if (out_free) begin
            out_r   <= res;
            state_r <= wipe_now ? S_CLEAR : S_IDLE;
          end else begin
            pend_r  <= res;
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_r   <= pend_r;
            state_r <= wipe_r ? S_CLEAR : S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  // Configuration registers are always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= GRID_WIDTH_RST;
      grid_height_r    <= GRID_HEIGHT_RST;
      start_col_r      <= START_COL_RST;
      start_row_r      <= START_ROW_RST;
      start_heading_r  <= START_HEADING_RST;
      flip_threshold_r <= FLIP_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:     grid_width_r     <= cfg_data[10:0];
        REG_GRID_HEIGHT:    grid_height_r    <= cfg_data[10:0];
        REG_START_COL:      start_col_r      <= cfg_data[9:0];
        REG_START_ROW:      start_row_r      <= cfg_data[9:0];
        REG_START_HEADING:  start_heading_r  <= cfg_data[1:0];
        REG_FLIP_THRESHOLD: flip_threshold_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  nla_grid_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_grid (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The block takes a new request only between items and outside a clearing pass.
  assign in_stall = (state_r != S_IDLE);

  assign out_valid       = out_valid_r;
  assign out_flipped_col = out_r.flipped_col;
  assign out_flipped_row = out_r.flipped_row;
  assign out_new_colour  = out_r.new_colour;
  assign out_did_flip    = out_r.did_flip;
  assign out_ant_col     = out_r.ant_col;
  assign out_ant_row     = out_r.ant_row;
  assign out_ant_heading = out_r.ant_heading;
  assign out_escaped     = out_r.escaped;

endmodule

@@ src/nla_checker.sv @@
// ----------------------------------------------------------------------------
// nla_checker - port-level checks for the Langton's ant stepper
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module nla_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [9:0]        out_flipped_col,
  input logic [9:0]        out_flipped_row,
  input logic              out_new_colour,
  input logic              out_did_flip,
  input logic signed [11:0] out_ant_col
);

  // A result held back by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its ant column.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_ant_col))
    else $error("result position changed while stalled");

  // One request at a time: after an accepted request the block is busy.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in progress");

  // Without a flip the flipped-cell fields read zero.
  a_noflip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_did_flip |->
      out_flipped_col == 10'd0 && out_flipped_row == 10'd0 && !out_new_colour)
    else $error("flipped-cell fields set without a flip");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind noisy_langtons_ant_step nla_checker u_nla_checker (.*);
